FILE: rtl/core/hpc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the hard-point chain collision step.
// No dependencies; hpc_front, hpc_back and the top level import this package.
package hpc_pkg;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_PRED = 2'd1,
    OP_PERF = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_WELL = 2'd0,
    CFG_MEVEN = 2'd1,
    CFG_MODD = 2'd2,
    CFG_MPROD = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RD_I,
    ST_RD_NX,
    ST_RD_PV,
    ST_RD_N2,
    ST_RD_END,
    ST_DECIDE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_WR_NX,
    ST_WR_PV,
    ST_WR_I,
    ST_RESULT
  } state_t;

  // multiply passes of a perform, in issue order
  typedef enum logic [3:0] {
    MS_JR, MS_JN, MS_JP, MS_GNX, MS_GPV, MS_AH, MS_AN, MS_VTOT,
    MS_VI, MS_VNX, MS_GI, MS_JRD, MS_PM, MS_EN
  } mstep_t;

  typedef struct packed {
    op_t         op;
    logic        kind;
    logic [63:0] etime;
    logic [63:0] lgap;
    logic [63:0] lvel;
    logic [63:0] ltime;
  } item_t;

  typedef struct packed {
    logic [62:0] well_width;
    logic [62:0] mass_ratio_even;
    logic [62:0] mass_ratio_odd;
    logic [62:0] mass_product;
  } cfg_t;

  localparam logic [62:0] CFG_RESET = 63'h1_0000_0000;
  localparam logic [63:0] DELTA = 64'd4294967;
  localparam logic [63:0] HALF = 64'd2147483648;

endpackage

FILE: rtl/core/hpc_ram.sv
`timescale 1ns / 1ps
// Generic single-port RAM with registered read data.
// No dependencies.
module hpc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

FILE: rtl/core/hpc_mul.sv
`timescale 1ns / 1ps
// Shared Q32.32 multiplier: four registered 32x32 partial products.
// No dependencies; result is (a*b) >>> 32, low 64 bits.
module hpc_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] y
);
  logic         busy;
  logic [2:0]   cnt;
  logic [63:0]  xm, ym;
  logic         neg;
  logic [63:0]  pp;
  logic [1:0]   sh;
  logic [127:0] acc;
  logic [31:0]  xs, ys;
  logic [127:0] pp_sh, prod;

  assign xs = cnt[0] ? xm[63:32] : xm[31:0];
  assign ys = cnt[1] ? ym[63:32] : ym[31:0];
  assign pp_sh = {64'b0, pp} << {sh, 5'b0};
  assign prod = neg ? (128'd0 - acc) : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 3'd0;
        xm <= a[63] ? (64'd0 - a) : a;
        ym <= b[63] ? (64'd0 - b) : b;
        neg <= a[63] ^ b[63];
        acc <= '0;
      end else if (busy) begin
        if (cnt < 3'd4) begin
          pp <= xs * ys;
          sh <= {1'b0, cnt[0]} + {1'b0, cnt[1]};
        end
        if (cnt != 3'd0 && cnt != 3'd5) begin
          acc <= acc + pp_sh;
        end
        if (cnt == 3'd5) begin
          y <= prod[95:32];
          done <= 1'b1;
          busy <= 1'b0;
        end
        cnt <= cnt + 3'd1;
      end
    end
  end
endmodule

FILE: rtl/core/hpc_div.sv
`timescale 1ns / 1ps
// Bit-serial Q32.32 divider: (a << 32) / b truncated toward zero, one bit a cycle.
// No dependencies; b must be nonzero.
module hpc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] q
);
  logic        busy;
  logic [6:0]  cnt;
  logic [95:0] dvd;
  logic [63:0] d, rem, quo;
  logic        neg;
  logic [64:0] rem_sh;

  assign rem_sh = {rem, dvd[95]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= 7'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 7'd96;
        dvd <= {(a[63] ? (64'd0 - a) : a), 32'd0};
        d <= b[63] ? (64'd0 - b) : b;
        neg <= a[63] ^ b[63];
        rem <= '0;
        quo <= '0;
      end else if (busy) begin
        if (cnt != 7'd0) begin
          dvd <= {dvd[94:0], 1'b0};
          if (rem_sh >= {1'b0, d}) begin
            rem <= 64'(rem_sh - {1'b0, d});
            quo <= {quo[62:0], 1'b1};
          end else begin
            rem <= rem_sh[63:0];
            quo <= {quo[62:0], 1'b0};
          end
          cnt <= cnt - 7'd1;
        end else begin
          q <= neg ? (64'd0 - quo) : quo;
          done <= 1'b1;
          busy <= 1'b0;
        end
      end
    end
  end
endmodule

FILE: rtl/core/hpc_front.sv
`timescale 1ns / 1ps
// Front end: takes requests, reduces the site onto the ring, finds neighbors,
// and holds up to two decoded requests for the back end. Depends on hpc_pkg.
module hpc_front #(
  parameter int SITES = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  hpc_pkg::item_t               in_item,
  input  logic [9:0]                   in_site,
  output logic                         q_valid,
  input  logic                         q_ready,
  output hpc_pkg::item_t               q_item,
  output logic [$clog2(SITES)-1:0]     q_i,
  output logic [$clog2(SITES)-1:0]     q_nx,
  output logic [$clog2(SITES)-1:0]     q_pv,
  output logic [$clog2(SITES)-1:0]     q_n2
);
  import hpc_pkg::*;

  localparam int IW = $clog2(SITES);
  localparam int IW1 = IW + 1;
  localparam int unsigned RECIP = (1 << 20) / SITES;

  logic [31:0]    q_est, r_est;
  logic [IW-1:0]  i_w, nx_w, pv_w, n2_w;
  logic [IW1-1:0] i_e, p1, p2;

  item_t         e_item [2];
  logic [IW-1:0] e_i [2], e_nx [2], e_pv [2], e_n2 [2];
  logic          wp, rp;
  logic [1:0]    count;
  logic          push, pop;

  // reduce the site by a reciprocal multiply; the quotient estimate is at most one short
  assign q_est = (32'(in_site) * RECIP) >> 20;
  assign r_est = 32'(in_site) - q_est * 32'(SITES);
  assign i_w = (r_est >= 32'(SITES)) ? IW'(r_est - 32'(SITES)) : IW'(r_est);
  assign i_e = {1'b0, i_w};
  assign p1 = i_e + IW1'(1);
  assign p2 = i_e + IW1'(2);
  assign nx_w = (p1 == IW1'(SITES)) ? '0 : p1[IW-1:0];
  assign n2_w = (p2 >= IW1'(SITES)) ? IW'(p2 - IW1'(SITES)) : p2[IW-1:0];
  assign pv_w = (i_w == '0) ? IW'(SITES - 1) : IW'(i_e - IW1'(1));

  assign in_ready = (count != 2'd2);
  assign q_valid = (count != 2'd0);
  assign push = in_valid && in_ready;
  assign pop = q_valid && q_ready;

  assign q_item = e_item[rp];
  assign q_i = e_i[rp];
  assign q_nx = e_nx[rp];
  assign q_pv = e_pv[rp];
  assign q_n2 = e_n2[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        e_item[wp] <= in_item;
        e_i[wp] <= i_w;
        e_nx[wp] <= nx_w;
        e_pv[wp] <= pv_w;
        e_n2[wp] <= n2_w;
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

FILE: rtl/core/hpc_back.sv
`timescale 1ns / 1ps
// Back end: sequencer over the site stores, shared multiplier and divider,
// and the result register. Depends on hpc_pkg, hpc_ram, hpc_mul and hpc_div.
module hpc_back #(
  parameter int SITES = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  input  hpc_pkg::cfg_t            cfg,
  input  logic                     q_valid,
  output logic                     q_ready,
  input  hpc_pkg::item_t           q_item,
  input  logic [$clog2(SITES)-1:0] q_i,
  input  logic [$clog2(SITES)-1:0] q_nx,
  input  logic [$clog2(SITES)-1:0] q_pv,
  input  logic [$clog2(SITES)-1:0] q_n2,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               out_user,
  output logic [383:0]             out_data
);
  import hpc_pkg::*;

  localparam int IW = $clog2(SITES);

  state_t state, state_next;
  mstep_t step;
  item_t  it;
  logic [IW-1:0] si, snx, spv, sn2;

  logic [63:0] g_i, v_i, t_i, g_nx, v_nx, t_nx, g_pv, v_pv, t_pv, v_n2;
  logic [63:0] jr, jn, jp, gnx, gpv, sab, vtot, vi, vnx, gi, pm, en;
  logic        res_active, res_kind;
  logic [63:0] res_time;

  logic [IW-1:0] ram_addr;
  logic          g_we, v_we, t_we;
  logic [63:0]   g_wd, v_wd, t_wd, g_rd, v_rd, t_rd;

  logic        mul_start, mul_done, div_start, div_done;
  logic [63:0] mul_a, mul_b, mul_y, div_a, div_q;
  logic [63:0] u, mh, mn, ww;

  assign u = v_nx - v_i;
  assign ww = {1'b0, cfg.well_width};
  assign mh = {1'b0, si[0] ? cfg.mass_ratio_odd : cfg.mass_ratio_even};
  assign mn = {1'b0, si[0] ? cfg.mass_ratio_even : cfg.mass_ratio_odd};
  assign div_a = u[63] ? g_i : (ww - g_i);

  hpc_ram #(.WIDTH(64), .DEPTH(SITES)) u_gap (
    .clk(clk), .we(g_we), .addr(ram_addr), .wdata(g_wd), .rdata(g_rd)
  );
  hpc_ram #(.WIDTH(64), .DEPTH(SITES)) u_vel (
    .clk(clk), .we(v_we), .addr(ram_addr), .wdata(v_wd), .rdata(v_rd)
  );
  hpc_ram #(.WIDTH(64), .DEPTH(SITES)) u_time (
    .clk(clk), .we(t_we), .addr(ram_addr), .wdata(t_wd), .rdata(t_rd)
  );

  hpc_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .y(mul_y)
  );
  hpc_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .a(div_a), .b(u),
    .done(div_done), .q(div_q)
  );

  // operands of each multiply pass
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step)
      MS_JR: begin mul_a = t_i - it.etime; mul_b = v_i; end
      MS_JN: begin mul_a = t_nx - it.etime; mul_b = v_nx; end
      MS_JP: begin mul_a = t_pv - it.etime; mul_b = v_pv; end
      MS_GNX: begin mul_a = it.etime - t_nx; mul_b = v_n2 - v_nx; end
      MS_GPV: begin mul_a = it.etime - t_pv; mul_b = v_i - v_pv; end
      MS_AH: begin mul_a = mh; mul_b = v_i; end
      MS_AN: begin mul_a = mn; mul_b = v_nx; end
      MS_VTOT: begin mul_a = HALF; mul_b = sab; end
      MS_VI: begin mul_a = mn; mul_b = u; end
      MS_VNX: begin mul_a = mh; mul_b = u; end
      MS_GI: begin mul_a = DELTA; mul_b = vnx - vi; end
      MS_JRD: begin mul_a = DELTA; mul_b = vi; end
      MS_PM: begin mul_a = {1'b0, cfg.mass_product}; mul_b = u; end
      MS_EN: begin mul_a = vtot; mul_b = pm; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          case (q_item.op)
            OP_LOAD: state_next = ST_LOAD;
            OP_PRED, OP_PERF: state_next = ST_RD_I;
            default: state_next = ST_RESULT;
          endcase
        end
      end
      ST_LOAD: state_next = ST_RESULT;
      ST_RD_I: state_next = ST_RD_NX;
      ST_RD_NX: state_next = ST_RD_PV;
      ST_RD_PV: state_next = ST_RD_N2;
      ST_RD_N2: state_next = ST_RD_END;
      ST_RD_END: state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (it.op == OP_PERF) begin
          state_next = ST_MUL_GO;
        end else if (u == '0) begin
          state_next = ST_RESULT;
        end else begin
          state_next = ST_DIV_GO;
        end
      end
      ST_DIV_GO: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_done) state_next = ST_RESULT;
      ST_MUL_GO: state_next = ST_MUL_WAIT;
      ST_MUL_WAIT: begin
        if (mul_done) begin
          state_next = (step == MS_EN) ? ST_WR_NX : ST_MUL_GO;
        end
      end
      ST_WR_NX: state_next = ST_WR_PV;
      ST_WR_PV: state_next = ST_WR_I;
      ST_WR_I: state_next = ST_RESULT;
      ST_RESULT: if (!out_valid || out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_ready = (state == ST_IDLE);
    mul_start = (state == ST_MUL_GO);
    div_start = (state == ST_DIV_GO);
    ram_addr = si;
    g_we = 1'b0;
    v_we = 1'b0;
    t_we = 1'b0;
    g_wd = '0;
    v_wd = '0;
    t_wd = '0;
    case (state)
      ST_LOAD: begin
        g_we = 1'b1; v_we = 1'b1; t_we = 1'b1;
        g_wd = it.lgap; v_wd = it.lvel; t_wd = it.ltime;
      end
      ST_RD_NX: ram_addr = snx;
      ST_RD_PV: ram_addr = spv;
      ST_RD_N2: ram_addr = sn2;
      ST_WR_NX: begin
        ram_addr = snx;
        g_we = 1'b1; v_we = 1'b1; t_we = 1'b1;
        g_wd = gnx; v_wd = vnx; t_wd = it.etime;
      end
      ST_WR_PV: begin
        ram_addr = spv;
        g_we = 1'b1; t_we = 1'b1;
        g_wd = gpv; t_wd = it.etime;
      end
      ST_WR_I: begin
        g_we = 1'b1; v_we = 1'b1; t_we = 1'b1;
        g_wd = gi; v_wd = vi; t_wd = it.etime + DELTA;
      end
      default: ram_addr = si;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step <= MS_JR;
    end else begin
      state <= state_next;
      if (state == ST_DECIDE) begin
        step <= MS_JR;
      end else if (state == ST_MUL_WAIT && mul_done && step != MS_EN) begin
        step <= mstep_t'(step + 4'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          it <= q_item;
          si <= q_i;
          snx <= q_nx;
          spv <= q_pv;
          sn2 <= q_n2;
          res_active <= 1'b0;
          res_kind <= 1'b0;
          res_time <= '0;
          jr <= '0; jn <= '0; jp <= '0; pm <= '0; en <= '0;
        end
      end
      ST_RD_NX: begin g_i <= g_rd; v_i <= v_rd; t_i <= t_rd; end
      ST_RD_PV: begin g_nx <= g_rd; v_nx <= v_rd; t_nx <= t_rd; end
      ST_RD_N2: begin g_pv <= g_rd; v_pv <= v_rd; t_pv <= t_rd; end
      ST_RD_END: v_n2 <= v_rd;
      ST_DECIDE: begin
        if (it.op == OP_PRED && u != '0) begin
          res_active <= 1'b1;
          res_kind <= ~u[63];
        end
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          res_time <= u[63] ? (t_i - div_q) : (t_i + div_q);
        end
      end
      ST_MUL_WAIT: begin
        if (mul_done) begin
          case (step)
            MS_JR: jr <= mul_y;
            MS_JN: jn <= mul_y;
            MS_JP: jp <= mul_y;
            MS_GNX: gnx <= g_nx + mul_y;
            MS_GPV: gpv <= g_pv + mul_y;
            MS_AH: sab <= mul_y;
            MS_AN: sab <= sab + mul_y;
            MS_VTOT: vtot <= mul_y;
            MS_VI: vi <= v_i + mul_y;
            MS_VNX: vnx <= v_nx - mul_y;
            MS_GI: gi <= (it.kind ? ww : 64'd0) + mul_y;
            MS_JRD: jr <= jr - mul_y;
            MS_PM: pm <= 64'd0 - mul_y;
            MS_EN: en <= mul_y;
            default: en <= en;
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  // result register: hold until taken, refill in the same cycle it drains
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_RESULT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
      out_user <= {res_kind, res_active};
      out_data <= {en, pm, jp, jn, jr, res_time};
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end
endmodule

FILE: rtl/core/hard_point_chain_collision_step_top.sv
`timescale 1ns / 1ps
// Top level of the hard-point chain collision step: ports, configuration
// registers, front end and back end. Depends on hpc_pkg, hpc_front, hpc_back.

// One request is worked at a time while the front end queues up to two more.
// A predict runs through the bit-serial divider (96 steps, one quotient bit
// per cycle) unless the velocities are equal. A perform runs fourteen passes
// through the shared multiplier, each of four 32x32 partial products, plus
// site reads and write-back on single-port stores. No clearing pass: site
// stores hold garbage until loaded. Configuration writes are always accepted
// and must only come while the block is idle.
module hard_point_chain_collision_step_top #(
  parameter int SITES = 1024
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // site[9:0], event_time[73:10], load_gap[137:74], load_velocity[201:138],
  // load_time[265:202], zero pad[271:266]
  input  logic [271:0] s_tdata,
  // opcode[1:0], event_kind[2]
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // event_time_out[63:0], flux_gap[127:64], flux_gap_next[191:128],
  // flux_gap_prev[255:192], flux_momentum[319:256], flux_energy[383:320]
  output logic [383:0] m_tdata,
  // event_active[0], event_kind_out[1]
  output logic [1:0]   m_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_data
);
  import hpc_pkg::*;

  localparam int IW = $clog2(SITES);

  cfg_t          cfg;
  item_t         in_item, q_item;
  logic          q_valid, q_ready;
  logic [IW-1:0] q_i, q_nx, q_pv, q_n2;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.well_width <= CFG_RESET;
      cfg.mass_ratio_even <= CFG_RESET;
      cfg.mass_ratio_odd <= CFG_RESET;
      cfg.mass_product <= CFG_RESET;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_WELL: cfg.well_width <= cfg_data[62:0];
        CFG_MEVEN: cfg.mass_ratio_even <= cfg_data[62:0];
        CFG_MODD: cfg.mass_ratio_odd <= cfg_data[62:0];
        CFG_MPROD: cfg.mass_product <= cfg_data[62:0];
        default: cfg.mass_product <= cfg.mass_product;
      endcase
    end
  end

  always_comb begin
    in_item.op = op_t'(s_tuser[1:0]);
    in_item.kind = s_tuser[2];
    in_item.etime = s_tdata[73:10];
    in_item.lgap = s_tdata[137:74];
    in_item.lvel = s_tdata[201:138];
    in_item.ltime = s_tdata[265:202];
  end

  hpc_front #(.SITES(SITES)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .in_item(in_item), .in_site(s_tdata[9:0]),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .q_i(q_i), .q_nx(q_nx), .q_pv(q_pv), .q_n2(q_n2)
  );

  hpc_back #(.SITES(SITES)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .q_i(q_i), .q_nx(q_nx), .q_pv(q_pv), .q_n2(q_n2),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .out_user(m_tuser), .out_data(m_tdata)
  );
endmodule

FILE: dv/hpc_scoreboard.sv
`timescale 1ns / 1ps
// Checker for the hard-point chain collision step: mirrors site stores and
// registers, predicts each result and compares. Depends on hpc_pkg.
module hpc_scoreboard (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [271:0] s_tdata,
  input  logic [2:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [383:0] m_tdata,
  input  logic [1:0]   m_tuser,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  output int           errors,
  output int           pending
);
  import hpc_pkg::*;

  localparam int NSITES = 1024;

  typedef struct packed {
    logic        active;
    logic        kind;
    logic [63:0] etime;
    logic [63:0] flux_gap;
    logic [63:0] flux_next;
    logic [63:0] flux_prev;
    logic [63:0] flux_mom;
    logic [63:0] flux_energy;
  } outcome_t;

  logic [63:0] gap_mem [NSITES];
  logic [63:0] vel_mem [NSITES];
  logic [63:0] lt_mem [NSITES];
  logic [62:0] well, m_even, m_odd, m_prod;
  outcome_t    outcomes_due [$];

  // Q32.32 product: bits [95:32] of the exact signed product
  function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
    logic signed [127:0] x, y, p;
    x = {{64{a[63]}}, a};
    y = {{64{b[63]}}, b};
    p = x * y;
    return p[95:32];
  endfunction

  // (a << 32) / b on magnitudes, truncated, sign applied afterwards
  function automatic logic [63:0] qdiv(logic [63:0] a, logic [63:0] b);
    logic [63:0] n, d;
    logic [95:0] q;
    n = a[63] ? -a : a;
    d = b[63] ? -b : b;
    q = {n, 32'd0} / {32'd0, d};
    return (a[63] != b[63]) ? -q[63:0] : q[63:0];
  endfunction

  function automatic outcome_t collide_step(logic [271:0] d, logic [2:0] u_in);
    outcome_t r;
    logic [9:0] i, nx, pv, n2;
    logic [63:0] t_ev, u, jr, jn, jp, mh, mn, vtot, pm;
    r = '0;
    i = d[9:0];
    nx = i + 10'd1;
    pv = i - 10'd1;
    n2 = i + 10'd2;
    t_ev = d[73:10];
    case (op_t'(u_in[1:0]))
      OP_LOAD: begin
        gap_mem[i] = d[137:74];
        vel_mem[i] = d[201:138];
        lt_mem[i] = d[265:202];
      end
      OP_PRED: begin
        u = vel_mem[nx] - vel_mem[i];
        if (u != 0) begin
          r.active = 1'b1;
          if (u[63]) begin
            r.etime = lt_mem[i] - qdiv(gap_mem[i], u);
          end else begin
            r.kind = 1'b1;
            r.etime = lt_mem[i] + qdiv({1'b0, well} - gap_mem[i], u);
          end
        end
      end
      OP_PERF: begin
        jr = qmul(lt_mem[i] - t_ev, vel_mem[i]);
        jn = qmul(lt_mem[nx] - t_ev, vel_mem[nx]);
        jp = qmul(lt_mem[pv] - t_ev, vel_mem[pv]);
        gap_mem[nx] += qmul(t_ev - lt_mem[nx], vel_mem[n2] - vel_mem[nx]);
        gap_mem[pv] += qmul(t_ev - lt_mem[pv], vel_mem[i] - vel_mem[pv]);
        lt_mem[nx] = t_ev;
        lt_mem[pv] = t_ev;
        u = vel_mem[nx] - vel_mem[i];
        gap_mem[i] = u_in[2] ? {1'b0, well} : 64'd0;
        lt_mem[i] = t_ev;
        mh = i[0] ? {1'b0, m_odd} : {1'b0, m_even};
        mn = i[0] ? {1'b0, m_even} : {1'b0, m_odd};
        vtot = qmul(HALF, qmul(mh, vel_mem[i]) + qmul(mn, vel_mem[nx]));
        vel_mem[i] += qmul(mn, u);
        vel_mem[nx] -= qmul(mh, u);
        gap_mem[i] += qmul(DELTA, vel_mem[nx] - vel_mem[i]);
        jr -= qmul(DELTA, vel_mem[i]);
        lt_mem[i] += DELTA;
        pm = -qmul({1'b0, m_prod}, u);
        r.flux_gap = jr;
        r.flux_next = jn;
        r.flux_prev = jp;
        r.flux_mom = pm;
        r.flux_energy = qmul(vtot, pm);
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic compare_result(outcome_t e, outcome_t a);
    logic [63:0] ev [8];
    logic [63:0] av [8];
    string nm [8];
    nm = '{"event_active", "event_kind_out", "event_time_out", "flux_gap",
           "flux_gap_next", "flux_gap_prev", "flux_momentum", "flux_energy"};
    ev = '{e.active, e.kind, e.etime, e.flux_gap, e.flux_next, e.flux_prev,
           e.flux_mom, e.flux_energy};
    av = '{a.active, a.kind, a.etime, a.flux_gap, a.flux_next, a.flux_prev,
           a.flux_mom, a.flux_energy};
    for (int k = 0; k < 8; k++) begin
      if (ev[k] !== av[k]) begin
        errors++;
        if (errors <= 10)
          $display("MISMATCH %s: expected %h actual %h", nm[k], ev[k], av[k]);
      end
    end
  endtask

  assign pending = outcomes_due.size();

  always @(posedge clk) begin
    outcome_t got;
    if (rst) begin
      well <= CFG_RESET;
      m_even <= CFG_RESET;
      m_odd <= CFG_RESET;
      m_prod <= CFG_RESET;
      outcomes_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_WELL:  well <= cfg_data[62:0];
          CFG_MEVEN: m_even <= cfg_data[62:0];
          CFG_MODD:  m_odd <= cfg_data[62:0];
          CFG_MPROD: m_prod <= cfg_data[62:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        outcomes_due.push_back(collide_step(s_tdata, s_tuser));
      if (m_tvalid && m_tready) begin
        got = {m_tuser[0], m_tuser[1], m_tdata[63:0], m_tdata[127:64],
               m_tdata[191:128], m_tdata[255:192], m_tdata[319:256],
               m_tdata[383:320]};
        if (outcomes_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("MISMATCH: result with nothing expected");
        end else begin
          compare_result(outcomes_due.pop_front(), got);
        end
      end
    end
  end

  initial errors = 0;

endmodule

FILE: dv/hard_point_chain_collision_step_top_tb.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the hard-point chain collision step: loads, predicts
// and performs under several register settings. Depends on hpc_pkg, hpc_scoreboard.
module hard_point_chain_collision_step_top_tb;
  import hpc_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [271:0] s_tdata = '0;
  logic [2:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [383:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [63:0]  cfg_data = '0;
  int           errors, pending;
  int           cycles = 0;
  int           n_req = 0;
  int           rx_stall = 0;
  logic         m_took = 1'b0;
  logic         no_idle = 1'b0;
  bit           loaded [1024];

  always #1 clk = ~clk;

  hard_point_chain_collision_step_top DUT (.*);

  hpc_scoreboard checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    m_took <= m_tvalid && m_tready;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // draw a new stall after every accepted result
  always @(negedge clk) begin
    if (!rst) begin
      if (m_took) rx_stall = no_idle ? 0 : $urandom_range(0, 18);
      if (rx_stall > 0) begin
        m_tready <= 1'b0;
        rx_stall--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  function automatic logic [63:0] pick_value();
    logic [63:0] x;
    x = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0, 1: return x;
      2: return {{30{x[33]}}, x[33:0]};
      3: return {28'd0, x[35:0]};
      4: return {{26{x[37]}}, x[37:0]};
      default: begin
        case ($urandom_range(0, 4))
          0: return 64'd0;
          1: return 64'h7fff_ffff_ffff_ffff;
          2: return 64'h8000_0000_0000_0000;
          3: return 64'hffff_ffff_ffff_ffff;
          default: return 64'd1;
        endcase
      end
    endcase
  endfunction

  task automatic send_request(op_t op, logic kind, logic [9:0] site, logic [63:0] et,
                              logic [63:0] g, logic [63:0] v, logic [63:0] t);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 18);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= {kind, op};
    s_tdata <= {6'd0, t, v, g, et, site};
    do @(posedge clk); while (!s_tready);
    if (op == OP_LOAD) loaded[site] = 1'b1;
    n_req++;
  endtask

  task automatic load_site(logic [9:0] site);
    send_request(OP_LOAD, 1'($urandom_range(0, 1)), site, pick_value(), pick_value(),
                 pick_value(), pick_value());
  endtask

  // load every site whose values the request uses before sending it
  task automatic site_request(op_t op, logic kind, logic [9:0] site, logic [63:0] et);
    logic [9:0] need [4];
    need = '{site, site + 10'd1, site - 10'd1, site + 10'd2};
    if (op == OP_PRED || op == OP_PERF)
      for (int k = 0; k < ((op == OP_PERF) ? 4 : 2); k++)
        if (!loaded[need[k]]) load_site(need[k]);
    send_request(op, kind, site, et, pick_value(), pick_value(), pick_value());
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [63:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(int count);
    op_t op;
    logic [9:0] site;
    for (int n = 0; n < count; n++) begin
      if (n % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 19))
        0, 1, 2: op = OP_LOAD;
        3: op = OP_NONE;
        4, 5, 6, 7, 8, 9, 10, 11: op = OP_PRED;
        default: op = OP_PERF;
      endcase
      // stay mostly on a few sites around the ring seam so state builds up
      site = ($urandom_range(0, 9) < 6) ? 10'($urandom_range(0, 7) - 4)
                                        : 10'($urandom_range(0, 1023));
      site_request(op, 1'($urandom_range(0, 1)), site, pick_value());
    end
    no_idle = 1'b0;
  endtask

  initial begin
    logic [63:0] regs [4];
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // extremes of the load fields, then each operation on both parities
    send_request(OP_LOAD, 1'b0, 10'd0, '0, 64'h7fff_ffff_ffff_ffff,
                 64'h8000_0000_0000_0000, 64'hffff_ffff_ffff_ffff);
    send_request(OP_LOAD, 1'b1, 10'd1, '1, 64'h0000_0000_8000_0000,
                 64'h8000_0000_0000_0000, 64'd0);
    send_request(OP_LOAD, 1'b0, 10'd1023, '0, 64'h0000_0000_4000_0000,
                 64'h0000_0002_0000_0000, 64'h0000_0001_0000_0000);
    send_request(OP_LOAD, 1'b0, 10'd2, '0, 64'h0000_0000_2000_0000,
                 64'hffff_fffe_0000_0000, 64'h0000_0003_0000_0000);
    send_request(OP_LOAD, 1'b0, 10'd3, '0, 64'd0, 64'h0000_0001_0000_0000, 64'd0);
    site_request(OP_PRED, 1'b0, 10'd0, '0);    // equal velocities: no event
    site_request(OP_PRED, 1'b0, 10'd1, '0);    // separating
    site_request(OP_PRED, 1'b0, 10'd2, '0);    // separating
    site_request(OP_PRED, 1'b0, 10'd1023, '0); // wraps to site 0
    site_request(OP_PERF, 1'b0, 10'd1, 64'h0000_0001_0000_0000);
    site_request(OP_PERF, 1'b1, 10'd2, 64'h7fff_ffff_ffff_ffff);
    site_request(OP_PERF, 1'b0, 10'd0, 64'h8000_0000_0000_0000);
    site_request(OP_PERF, 1'b1, 10'd1023, 64'hffff_ffff_ffff_ffff);
    site_request(OP_NONE, 1'b1, 10'd1023, '1);
    site_request(OP_NONE, 1'b0, 10'd512, '0);
    send_request(OP_LOAD, 1'b0, 10'h2aa, '1, '1, '1, '1);
    send_request(OP_LOAD, 1'b1, 10'h155, '0, '0, '0, '0);

    random_phase(160);
    drain();

    // register settings: all ones, all zero, small and random
    for (int ph = 0; ph < 4; ph++) begin
      for (int r = 0; r < 4; r++) begin
        case (ph)
          0: regs[r] = 64'hffff_ffff_ffff_ffff;
          1: regs[r] = 64'd0;
          2: regs[r] = {30'd0, 2'($urandom_range(0, 3)), $urandom};
          default: regs[r] = {$urandom, $urandom};
        endcase
        write_reg(cfg_idx_t'(r), regs[r]);
      end
      random_phase(160);
      drain();
    end

    repeat (300) @(posedge clk);
    $display("Run sent %0d requests: loads, predicts, performs and the unused opcode", n_req);
    $display("under reset, all-ones, zero, small and random register settings.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
